/* hw/rtl/sprq_pkg.sv */
// Shared types, codes and sizes for the sortable priority ring queue.
package sprq_pkg;

   localparam int MaxEntries = 64;
   localparam int CountWidth = $clog2(MaxEntries + 1);
   localparam int CapWidth   = 7;
   localparam int CmpWidth   = (CountWidth > CapWidth) ? CountWidth : CapWidth;

   localparam logic [CapWidth-1:0] CapReset = CapWidth'(64);

   localparam logic [2:0] ActEnqueue = 3'd0;
   localparam logic [2:0] ActDequeue = 3'd1;
   localparam logic [2:0] ActPeek    = 3'd2;
   localparam logic [2:0] ActReduce  = 3'd3;
   localparam logic [2:0] ActSort    = 3'd4;

   localparam logic [1:0] StatusOk    = 2'd0;
   localparam logic [1:0] StatusFull  = 2'd1;
   localparam logic [1:0] StatusEmpty = 2'd2;

   localparam logic [2:0] CellHold   = 3'd0;
   localparam logic [2:0] CellLoad   = 3'd1;
   localparam logic [2:0] CellShift  = 3'd2;
   localparam logic [2:0] CellReduce = 3'd3;
   localparam logic [2:0] CellSort   = 3'd4;

   typedef struct packed {
      logic [2:0]         action;
      logic signed [31:0] entry_priority;
      logic [31:0]        entry_tag;
      logic signed [31:0] reduce_amount;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [31:0] head_priority;
      logic [31:0]        head_tag;
   } rsp_type;

   // Broadcast to every cell in the row.
   typedef struct packed {
      logic [2:0]         op;
      logic signed [31:0] new_priority;
      logic [31:0]        new_tag;
      logic signed [31:0] amount;
   } cell_ctrl_type;

   // Selects that differ from cell to cell.
   typedef struct packed {
      logic load_en;
      logic pair_en;
   } cell_sel_type;

endpackage

/* hw/rtl/sprq_cell.sv */
// One queue cell: holds a single (priority, tag) entry and trades it with its neighbors.
module sprq_cell (
   input  logic                   clock,
   input  sprq_pkg::cell_ctrl_type ctrl,
   input  sprq_pkg::cell_sel_type  sel,
   input  logic signed [31:0]     left_priority,
   input  logic [31:0]            left_tag,
   input  logic                   left_swap,
   input  logic signed [31:0]     right_priority,
   input  logic [31:0]            right_tag,
   output logic signed [31:0]     cell_priority,
   output logic [31:0]            cell_tag,
   output logic                   swap_right
);

   logic signed [31:0] pri_ff, pri_in;
   logic [31:0]        tag_ff, tag_in;

   // Swapping only on a strictly greater left entry keeps equal priorities in order.
   assign swap_right = sel.pair_en && (pri_ff > right_priority);

   always_comb begin
      pri_in = pri_ff;
      tag_in = tag_ff;
      case (ctrl.op)
         sprq_pkg::CellLoad: begin
            if (sel.load_en) begin
               pri_in = ctrl.new_priority;
               tag_in = ctrl.new_tag;
            end
         end
         sprq_pkg::CellShift: begin
            pri_in = right_priority;
            tag_in = right_tag;
         end
         sprq_pkg::CellReduce: begin
            pri_in = pri_ff - ctrl.amount;
         end
         sprq_pkg::CellSort: begin
            if (swap_right) begin
               pri_in = right_priority;
               tag_in = right_tag;
            end else if (left_swap) begin
               pri_in = left_priority;
               tag_in = left_tag;
            end
         end
         default: begin
            pri_in = pri_ff;
            tag_in = tag_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      pri_ff <= pri_in;
      tag_ff <= tag_in;
   end

   assign cell_priority = pri_ff;
   assign cell_tag      = tag_ff;

endmodule

/* hw/rtl/sortable_priority_ring_queue_unit.sv */
// Top level of the sortable priority ring queue: control, result register and the cell row.
//
// The queue keeps its entries in a row of cells in arrival order, the head in the
// first cell. For enqueue, dequeue, peek, reduce and unknown actions, the
// transaction is taken when start is high and busy is low, and its result appears
// on the rsp_ ports, marked by rsp_valid, in the following cycle.
// A sort of n live entries (n of two or more) runs n odd-even transposition passes,
// one per cycle, in which neighboring cells compare and exchange their entries;
// busy is high while the passes run and the result follows in the cycle after the
// last pass, so the next transaction can start once busy has fallen.
// Sorting is stable: equal priorities keep their arrival order. A sort of one
// entry or none behaves like the other actions. Results cannot be held off by the
// receiver; each is shown for exactly one cycle. The capacity register is written
// through the csr_ port, which is always ready; a capacity of zero acts as one,
// and lowering it below the current fill keeps the stored entries.
module sortable_priority_ring_queue_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  sprq_pkg::req_type                req_data,
   output logic                             rsp_valid,
   output sprq_pkg::rsp_type                rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sprq_pkg::CapWidth-1:0]    csr_wdata
);

   logic [sprq_pkg::CapWidth-1:0]   capacity_ff;
   logic [sprq_pkg::CountWidth-1:0] count_ff, count_in;
   logic [sprq_pkg::CountWidth-1:0] pass_ff, pass_in;
   logic                            phase_ff, phase_in;
   logic                            sort_active_ff, sort_active_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   sprq_pkg::rsp_type               rsp_data_ff, rsp_data_in;

   logic                            accept;
   logic                            full;
   logic [sprq_pkg::CapWidth-1:0]   cap_eff;
   sprq_pkg::cell_ctrl_type         ctrl;

   logic signed [31:0]              cell_pri  [sprq_pkg::MaxEntries];
   logic [31:0]                     cell_tag  [sprq_pkg::MaxEntries];
   logic                            cell_swap [sprq_pkg::MaxEntries];
   sprq_pkg::cell_sel_type          cell_sel  [sprq_pkg::MaxEntries];

   assign accept    = start && !sort_active_ff;
   assign busy      = sort_active_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A capacity of zero still admits one entry; the row size caps everything else.
   assign cap_eff = (capacity_ff == '0) ? sprq_pkg::CapWidth'(1) : capacity_ff;
   assign full    = (count_ff >= sprq_pkg::CountWidth'(sprq_pkg::MaxEntries)) ||
                    (sprq_pkg::CmpWidth'(count_ff) >= sprq_pkg::CmpWidth'(cap_eff));

   always_comb begin
      ctrl.op           = sprq_pkg::CellHold;
      ctrl.new_priority = req_data.entry_priority;
      ctrl.new_tag      = req_data.entry_tag;
      ctrl.amount       = req_data.reduce_amount;
      count_in          = count_ff;
      pass_in           = pass_ff;
      phase_in          = phase_ff;
      sort_active_in    = sort_active_ff;
      rsp_valid_in      = 1'b0;
      rsp_data_in       = '0;

      if (accept) begin
         rsp_valid_in = 1'b1;
         case (req_data.action)
            sprq_pkg::ActEnqueue: begin
               if (full) begin
                  rsp_data_in.status = sprq_pkg::StatusFull;
               end else begin
                  ctrl.op  = sprq_pkg::CellLoad;
                  count_in = count_ff + sprq_pkg::CountWidth'(1);
               end
            end
            sprq_pkg::ActDequeue, sprq_pkg::ActPeek: begin
               if (count_ff == '0) begin
                  rsp_data_in.status = sprq_pkg::StatusEmpty;
               end else begin
                  rsp_data_in.head_priority = cell_pri[0];
                  rsp_data_in.head_tag      = cell_tag[0];
                  if (req_data.action == sprq_pkg::ActDequeue) begin
                     ctrl.op  = sprq_pkg::CellShift;
                     count_in = count_ff - sprq_pkg::CountWidth'(1);
                  end
               end
            end
            sprq_pkg::ActReduce: begin
               if (count_ff == '0) begin
                  rsp_data_in.status = sprq_pkg::StatusEmpty;
               end else begin
                  ctrl.op = sprq_pkg::CellReduce;
               end
            end
            sprq_pkg::ActSort: begin
               // Two or more entries need the transposition passes; the result waits.
               if (count_ff > sprq_pkg::CountWidth'(1)) begin
                  rsp_valid_in   = 1'b0;
                  sort_active_in = 1'b1;
                  pass_in        = count_ff;
                  phase_in       = 1'b0;
               end
            end
            default: begin
               rsp_data_in = '0;
            end
         endcase
      end

      if (sort_active_ff) begin
         ctrl.op  = sprq_pkg::CellSort;
         pass_in  = pass_ff - sprq_pkg::CountWidth'(1);
         phase_in = ~phase_ff;
         if (pass_ff == sprq_pkg::CountWidth'(1)) begin
            sort_active_in = 1'b0;
            rsp_valid_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff    <= sprq_pkg::CapReset;
         count_ff       <= '0;
         pass_ff        <= '0;
         phase_ff       <= 1'b0;
         sort_active_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            capacity_ff <= csr_wdata;
         end
         count_ff       <= count_in;
         pass_ff        <= pass_in;
         phase_ff       <= phase_in;
         sort_active_ff <= sort_active_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // The cell row. Cell i pairs with cell i + 1 on passes whose phase matches the
   // parity of i, and only while both cells hold live entries.
   for (genvar i = 0; i < sprq_pkg::MaxEntries; i++) begin : g_cell
      localparam logic                            Parity = 1'(i % 2);
      localparam logic [sprq_pkg::CountWidth-1:0] Pos    = sprq_pkg::CountWidth'(i);
      localparam logic [sprq_pkg::CountWidth-1:0] Next   = sprq_pkg::CountWidth'(i + 1);

      logic signed [31:0] left_pri, right_pri;
      logic [31:0]        left_tag, right_tag;
      logic               left_swap;

      if (i == 0) begin : g_first
         assign left_pri  = '0;
         assign left_tag  = '0;
         assign left_swap = 1'b0;
      end else begin : g_inner_left
         assign left_pri  = cell_pri[i-1];
         assign left_tag  = cell_tag[i-1];
         assign left_swap = cell_swap[i-1];
      end

      if (i == sprq_pkg::MaxEntries - 1) begin : g_last
         assign right_pri = '0;
         assign right_tag = '0;
         assign cell_sel[i].pair_en = 1'b0;
      end else begin : g_inner_right
         assign right_pri = cell_pri[i+1];
         assign right_tag = cell_tag[i+1];
         assign cell_sel[i].pair_en = sort_active_ff && (phase_ff == Parity) &&
                                      (Next < count_ff);
      end

      assign cell_sel[i].load_en = (count_ff == Pos);

      sprq_cell u_cell (
         .clock          (clock),
         .ctrl           (ctrl),
         .sel            (cell_sel[i]),
         .left_priority  (left_pri),
         .left_tag       (left_tag),
         .left_swap      (left_swap),
         .right_priority (right_pri),
         .right_tag      (right_tag),
         .cell_priority  (cell_pri[i]),
         .cell_tag       (cell_tag[i]),
         .swap_right     (cell_swap[i])
      );
   end

   // A sort only runs passes when there is something to order.
   a_sort_needs_entries: assert property (@(posedge clock) disable iff (reset)
      sort_active_ff |-> (count_ff > sprq_pkg::CountWidth'(1)))
      else $error("sort running with fewer than two entries");

   // The fill never exceeds the row.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= sprq_pkg::CountWidth'(sprq_pkg::MaxEntries))
      else $error("entry count beyond cell row");

   // Every accepted non-sort transaction answers in the next cycle.
   a_one_cycle_answer: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.action != sprq_pkg::ActSort)) |=> rsp_valid)
      else $error("missing one-cycle result");

   // Dequeue from an empty queue reports empty and leaves the fill alone.
   a_empty_dequeue: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.action == sprq_pkg::ActDequeue) && (count_ff == '0))
      |=> (rsp_data.status == sprq_pkg::StatusEmpty) && (count_ff == '0))
      else $error("empty dequeue mishandled");

   // A finished sort hands back exactly one result and drops busy together.
   a_sort_finish: assert property (@(posedge clock) disable iff (reset)
      $fell(sort_active_ff) |-> rsp_valid_ff)
      else $error("sort ended without a result");

endmodule
